// ===== sv/front_to_back_matte_compositor_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the front-to-back matte compositor
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FRONT_TO_BACK_MATTE_COMPOSITOR_UNIT_DEFINES_SVH
`define FRONT_TO_BACK_MATTE_COMPOSITOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBMC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/fbmc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbmc_pkg
// Widths, fixed-point constants and arithmetic helpers of the compositor.
// ----------------------------------------------------------------------------
package fbmc_pkg;

	// Field widths.
	localparam int COLOR_W = 24;
	localparam int OPAC_W  = 16;
	localparam int T_W     = 16;
	localparam int LANES   = 3;

	// Q2.14 unity and fraction bits.
	localparam int ONE_Q14 = 16384;
	localparam int FRAC    = 14;

	// Widest product (transmittance times a color value) and derived sizes.
	localparam int PROD_W = T_W + COLOR_W;
	localparam int QUOT_W = PROD_W - FRAC;
	localparam int SUM_W  = QUOT_W + 1;

	// Default number of extra channel triples.
	localparam int EXTRA_CHANNELS_DEF = 1;

	typedef logic signed [COLOR_W-1:0] color_t;
	typedef logic signed [OPAC_W-1:0]  opac_t;
	typedef logic signed [T_W-1:0]     trans_t;

	// Per-sample control handed from the top level to every lane.
	typedef struct packed {
		logic upd;
		logic seed;
		logic matte;
		logic extra_mode;
	} ctl_t;

	// Divide a product by 16384, truncating toward zero.
	function automatic logic signed [QUOT_W-1:0] div_q14(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] adj;
		adj = p[PROD_W-1] ? p + PROD_W'(ONE_Q14 - 1) : p;
		return QUOT_W'(adj >>> FRAC);
	endfunction

	// Saturate a wide sum to the color width.
	function automatic color_t sat_color(input logic signed [SUM_W-1:0] x);
		if (&x[SUM_W-1:COLOR_W-1] || ~|x[SUM_W-1:COLOR_W-1]) begin
			return x[COLOR_W-1:0];
		end else if (x[SUM_W-1]) begin
			return {1'b1, {(COLOR_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COLOR_W-1){1'b1}}};
		end
	endfunction

	// Saturate a wide sum to 16 bits (opacity and transmittance).
	function automatic opac_t sat_16(input logic signed [SUM_W-1:0] x);
		if (&x[SUM_W-1:OPAC_W-1] || ~|x[SUM_W-1:OPAC_W-1]) begin
			return x[OPAC_W-1:0];
		end else if (x[SUM_W-1]) begin
			return {1'b1, {(OPAC_W-1){1'b0}}};
		end else begin
			return {1'b0, {(OPAC_W-1){1'b1}}};
		end
	endfunction

endpackage

// ===== sv/fbmc_if.sv =====
// ----------------------------------------------------------------------------
// fbmc_if
// Valid/ready channels of the compositor: samples, results and the register.
// ----------------------------------------------------------------------------

// Sample channel: one front-to-back sample per beat.
interface fbmc_sample_if;
	logic                    valid;
	logic                    ready;
	logic                    start_pixel;
	fbmc_pkg::color_t        color_r;
	fbmc_pkg::color_t        color_g;
	fbmc_pkg::color_t        color_b;
	fbmc_pkg::opac_t         opacity_r;
	fbmc_pkg::opac_t         opacity_g;
	fbmc_pkg::opac_t         opacity_b;
	fbmc_pkg::color_t        extra_r;
	fbmc_pkg::color_t        extra_g;
	fbmc_pkg::color_t        extra_b;

	modport source (output valid, start_pixel, color_r, color_g, color_b,
		opacity_r, opacity_g, opacity_b, extra_r, extra_g, extra_b, input ready);
	modport sink (input valid, start_pixel, color_r, color_g, color_b,
		opacity_r, opacity_g, opacity_b, extra_r, extra_g, extra_b, output ready);
endinterface

// Result channel: accumulators after each sample, one beat per sample.
interface fbmc_result_if;
	logic                    valid;
	logic                    ready;
	fbmc_pkg::color_t        sum_color_r;
	fbmc_pkg::color_t        sum_color_g;
	fbmc_pkg::color_t        sum_color_b;
	fbmc_pkg::opac_t         sum_opacity_r;
	fbmc_pkg::opac_t         sum_opacity_g;
	fbmc_pkg::opac_t         sum_opacity_b;
	fbmc_pkg::color_t        sum_extra_r;
	fbmc_pkg::color_t        sum_extra_g;
	fbmc_pkg::color_t        sum_extra_b;

	modport source (output valid, sum_color_r, sum_color_g, sum_color_b,
		sum_opacity_r, sum_opacity_g, sum_opacity_b,
		sum_extra_r, sum_extra_g, sum_extra_b, input ready);
	modport sink (input valid, sum_color_r, sum_color_g, sum_color_b,
		sum_opacity_r, sum_opacity_g, sum_opacity_b,
		sum_extra_r, sum_extra_g, sum_extra_b, output ready);
endinterface

// Register write channel: the matte mode of the extra channel.
interface fbmc_cfg_if;
	logic valid;
	logic ready;
	logic extra_matte_mode;

	modport source (output valid, extra_matte_mode, input ready);
	modport sink (input valid, extra_matte_mode, output ready);
endinterface

// ===== sv/fbmc_lane.sv =====
// ----------------------------------------------------------------------------
// fbmc_lane
// One color component: transmittance and accumulators with their update.
// ----------------------------------------------------------------------------
module fbmc_lane #(
	parameter int EXTRA_CHANNELS = fbmc_pkg::EXTRA_CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fbmc_pkg::ctl_t    ctl,
	input  fbmc_pkg::color_t  color,
	input  fbmc_pkg::opac_t   opacity,
	input  fbmc_pkg::color_t  extra,
	output fbmc_pkg::color_t  nxt_color,
	output fbmc_pkg::opac_t   nxt_opacity,
	output fbmc_pkg::color_t  nxt_extra
);

	localparam int FACT_W = fbmc_pkg::OPAC_W + 2;
	localparam int PROD_W = fbmc_pkg::PROD_W;
	localparam int SUM_W  = fbmc_pkg::SUM_W;

	fbmc_pkg::trans_t t_q;
	fbmc_pkg::color_t col_q;
	fbmc_pkg::opac_t  op_q;
	fbmc_pkg::color_t ext_q;
	fbmc_pkg::trans_t nxt_t;

	logic signed [FACT_W-1:0] f_norm;
	logic signed [FACT_W-1:0] f_matte;
	logic signed [FACT_W-1:0] factor;

	logic signed [fbmc_pkg::T_W+FACT_W-1:0]           p_t;
	logic signed [PROD_W-1:0]                         p_c;
	logic signed [fbmc_pkg::T_W+fbmc_pkg::OPAC_W-1:0] p_o;
	logic signed [PROD_W-1:0]                         p_e;

	logic signed [SUM_W-1:0] sum_t;
	logic signed [SUM_W-1:0] sum_c;
	logic signed [SUM_W-1:0] sum_o;
	logic signed [SUM_W-1:0] sum_e;

	// Transmittance factors 1 - opacity and 1 + opacity, exact.
	assign f_norm  = FACT_W'(fbmc_pkg::ONE_Q14) - FACT_W'(opacity);
	assign f_matte = FACT_W'(fbmc_pkg::ONE_Q14) + FACT_W'(opacity);
	assign factor  = ctl.matte ? f_matte : f_norm;

	// Products of the current transmittance, each one multiplier.
	assign p_t = t_q * factor;
	assign p_c = t_q * color;
	assign p_o = t_q * opacity;
	assign p_e = t_q * extra;

	// Quotients by unity, added to the accumulators.
	assign sum_t = SUM_W'(fbmc_pkg::div_q14(PROD_W'(p_t)));
	assign sum_c = SUM_W'(col_q) + SUM_W'(fbmc_pkg::div_q14(p_c));
	assign sum_o = SUM_W'(op_q) + SUM_W'(fbmc_pkg::div_q14(PROD_W'(p_o)));
	assign sum_e = SUM_W'(ext_q) + SUM_W'(fbmc_pkg::div_q14(p_e));

	// Next state: seed, later matte sample or later normal sample.
	always_comb begin
		if (ctl.seed) begin
			nxt_t       = fbmc_pkg::sat_16(SUM_W'(factor));
			nxt_color   = ctl.matte ? '0 : color;
			nxt_opacity = ctl.matte ? '0 : opacity;
			nxt_extra   = (ctl.matte && ctl.extra_mode) ? '0 : extra;
		end else if (ctl.matte) begin
			nxt_t       = fbmc_pkg::sat_16(sum_t);
			nxt_color   = col_q;
			nxt_opacity = op_q;
			nxt_extra   = ctl.extra_mode ? ext_q : extra;
		end else begin
			nxt_t       = fbmc_pkg::sat_16(sum_t);
			nxt_color   = fbmc_pkg::sat_color(sum_c);
			nxt_opacity = fbmc_pkg::sat_16(sum_o);
			nxt_extra   = fbmc_pkg::sat_color(sum_e);
		end
		// Without extra channels the extra accumulator stays cleared.
		if (EXTRA_CHANNELS == 0) begin
			nxt_extra = '0;
		end
	end

	// Lane state, updated once per sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q   <= '0;
			col_q <= '0;
			op_q  <= '0;
			ext_q <= '0;
		end else if (ctl.upd) begin
			t_q   <= nxt_t;
			col_q <= nxt_color;
			op_q  <= nxt_opacity;
			ext_q <= nxt_extra;
		end
	end

endmodule

// ===== sv/front_to_back_matte_compositor_unit.sv =====
// ----------------------------------------------------------------------------
// front_to_back_matte_compositor_unit
// Front-to-back RGB compositor with matte samples and one extra triple.
// ----------------------------------------------------------------------------
// Samples arrive on the sample channel nearest first; start_pixel marks the
// first sample of a pixel. Every accepted sample gives exactly one beat on
// the result channel carrying color, opacity and extra accumulators after
// that sample. The cfg channel writes extra_matte_mode; it is always ready
// and should only be written while no sample is in flight.
// The sample lands in the input register; the per-lane multiply-accumulate
// feeds the result register when the sample advances, and result valid
// comes from that register. Throughput is one sample per cycle while the
// receiver takes results; the loop through the accumulator registers (one
// multiplier, add and saturate) sets that rate.
// A stalled receiver holds the result register; the input register still
// takes one more sample, after which sample.ready drops until the result
// beat is taken.
// Reset clears the accumulators, the transmittance, the register and the
// seen-first-sample flag, so the first sample after reset seeds a pixel.
// ----------------------------------------------------------------------------
`include "front_to_back_matte_compositor_unit_defines.svh"

module front_to_back_matte_compositor_unit #(
	parameter int EXTRA_CHANNELS = fbmc_pkg::EXTRA_CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fbmc_sample_if.sink   sample,
	fbmc_result_if.source result,
	fbmc_cfg_if.sink      cfg
);

	localparam int LANES = fbmc_pkg::LANES;

	logic extra_matte_mode_q;
	logic has_base_q;

	// Input register stage.
	logic             v_s1;
	logic             start_s1;
	fbmc_pkg::color_t col_s1 [LANES];
	fbmc_pkg::opac_t  op_s1  [LANES];
	fbmc_pkg::color_t ext_s1 [LANES];

	// Result register stage.
	logic             v_s2;
	fbmc_pkg::color_t col_s2 [LANES];
	fbmc_pkg::opac_t  op_s2  [LANES];
	fbmc_pkg::color_t ext_s2 [LANES];

	fbmc_pkg::color_t nxt_col [LANES];
	fbmc_pkg::opac_t  nxt_op  [LANES];
	fbmc_pkg::color_t nxt_ext [LANES];

	logic           adv;
	logic           take;
	fbmc_pkg::ctl_t ctl;

	// Handshake: a sample advances when the result register is free or drains.
	assign adv          = v_s1 && (!v_s2 || result.ready);
	assign take         = sample.valid && sample.ready;
	assign sample.ready = !v_s1 || adv;
	assign cfg.ready    = 1'b1;

	// Control for the lanes: seeding, matte detection and the extra mode.
	assign ctl.upd        = adv;
	assign ctl.seed       = start_s1 || !has_base_q;
	assign ctl.matte      = op_s1[0][fbmc_pkg::OPAC_W-1] || op_s1[1][fbmc_pkg::OPAC_W-1]
		|| op_s1[2][fbmc_pkg::OPAC_W-1];
	assign ctl.extra_mode = extra_matte_mode_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extra_matte_mode_q <= 1'b0;
			has_base_q         <= 1'b0;
			v_s1               <= 1'b0;
			v_s2               <= 1'b0;
		end else begin
			if (cfg.valid) begin
				extra_matte_mode_q <= cfg.extra_matte_mode;
			end
			if (adv) begin
				has_base_q <= 1'b1;
			end
			if (sample.ready) begin
				v_s1 <= sample.valid;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	// Input payload register.
	always_ff @(posedge clk) begin
		if (take) begin
			start_s1  <= sample.start_pixel;
			col_s1[0] <= sample.color_r;
			col_s1[1] <= sample.color_g;
			col_s1[2] <= sample.color_b;
			op_s1[0]  <= sample.opacity_r;
			op_s1[1]  <= sample.opacity_g;
			op_s1[2]  <= sample.opacity_b;
			ext_s1[0] <= sample.extra_r;
			ext_s1[1] <= sample.extra_g;
			ext_s1[2] <= sample.extra_b;
		end
	end

	// One compositing lane per color component.
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		fbmc_lane #(
			.EXTRA_CHANNELS(EXTRA_CHANNELS)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.color      (col_s1[i]),
			.opacity    (op_s1[i]),
			.extra      (ext_s1[i]),
			.nxt_color  (nxt_col[i]),
			.nxt_opacity(nxt_op[i]),
			.nxt_extra  (nxt_ext[i])
		);
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (adv) begin
			col_s2 <= nxt_col;
			op_s2  <= nxt_op;
			ext_s2 <= nxt_ext;
		end
	end

	assign result.valid         = v_s2;
	assign result.sum_color_r   = col_s2[0];
	assign result.sum_color_g   = col_s2[1];
	assign result.sum_color_b   = col_s2[2];
	assign result.sum_opacity_r = op_s2[0];
	assign result.sum_opacity_g = op_s2[1];
	assign result.sum_opacity_b = op_s2[2];
	assign result.sum_extra_r   = ext_s2[0];
	assign result.sum_extra_g   = ext_s2[1];
	assign result.sum_extra_b   = ext_s2[2];

	// Both stages full with a stalled receiver must hold off new samples.
	`FBMC_ASSERT_SAME(a_full_stall, v_s1 && v_s2 && !result.ready, !sample.ready, "taken while full")
	// Every sample that leaves the input stage shows up as a result.
	`FBMC_ASSERT_NEXT(a_adv_result, adv, result.valid, "advanced sample produced no result")
	// After any sample the seen-first-sample flag is set.
	`FBMC_ASSERT_NEXT(a_seeded, adv, has_base_q, "pixel not seeded after a sample")

endmodule
